@@ rtl/borle_pkg.sv @@
package borle_pkg;

  // symbol lanes, one per packed bit of an input byte
  localparam int LANES  = 8;
  localparam int LANE_W = 3;
  localparam int NSYM_W = 4;
  localparam int SYM_W  = 8;
  localparam int CNT_W  = 15;
  // break records of all lanes plus the flush record
  localparam int RECS   = LANES + 1;

  // an open run is closed before it grows past this length
  localparam logic [CNT_W-1:0] RUN_LIMIT    = 15'd32766;
  // a packed bit of value v becomes the character '0' + v
  localparam logic [SYM_W-1:0] SYM_BIT_BASE = 8'h30;
  localparam logic [NSYM_W-1:0] BITS_MAX    = 4'd8;

  // one output record
  typedef struct packed {
    logic [SYM_W-1:0] value;
    logic [CNT_W-1:0] length;
    logic             last;
  } rec_t;

  // what one lane finds about its symbol
  typedef struct packed {
    logic             active;
    logic [SYM_W-1:0] sym;
    logic             chg;
    logic             lim_hit;
    logic [CNT_W-1:0] cnt_at;
  } lane_t;

endpackage

@@ rtl/borle_lane.sv @@
module borle_lane
  import borle_pkg::*;
(
  input  logic              mode_byte,
  input  logic              active,
  input  logic              data_bit,
  input  logic [SYM_W-1:0]  data_byte,
  input  logic              prev_open,
  input  logic [SYM_W-1:0]  prev_sym,
  input  logic [CNT_W-1:0]  run_count,
  input  logic [LANE_W-1:0] lane_idx,
  output lane_t             lane
);

  // symbol of this lane and its relation to the symbol before it
  always_comb begin
    lane.active = active;
    lane.sym    = mode_byte ? data_byte : (SYM_BIT_BASE | {{(SYM_W-1){1'b0}}, data_bit});
    lane.chg    = active && prev_open && (lane.sym != prev_sym);
    // run length ahead of this symbol when no break happened in lower lanes
    lane.cnt_at  = run_count + {{(CNT_W-LANE_W){1'b0}}, lane_idx};
    lane.lim_hit = (lane.cnt_at == RUN_LIMIT);
  end

endmodule

@@ rtl/borle_merge.sv @@
module borle_merge
  import borle_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  logic            load,
  input  logic [RECS-1:0] load_mask,
  input  rec_t            load_recs [RECS],
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output rec_t            out_rec
);

  logic [RECS-1:0] mask;
  rec_t            recs [RECS];
  logic [RECS-1:0] pick;
  logic [RECS-1:0] mask_left;
  rec_t            sel;
  logic            out_free;
  logic            pop;

  // oldest pending record is the lowest set bit
  always_comb begin
    pick = mask & RECS'(~mask + {{(RECS-1){1'b0}}, 1'b1});
    sel  = recs[0];
    for (int i = 0; i < RECS; i++) begin
      if (pick[i]) begin
        sel = recs[i];
      end
    end
    out_free  = !out_valid || out_ready;
    pop       = (|mask) && out_free;
    mask_left = pop ? (mask & ~pick) : mask;
    in_ready  = (mask_left == '0);
  end

  // pending record set
  always_ff @(posedge clk) begin
    if (rst) begin
      mask <= '0;
    end else if (load) begin
      mask <= load_mask;
    end else begin
      mask <= mask_left;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      recs <= load_recs;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= pop;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_rec <= sel;
    end
  end

`ifndef SYNTHESIS
  a_load_only_when_drained: assert property (@(posedge clk) disable iff (rst)
    load |-> (mask_left == '0))
    else $error("records of an item overwritten before they left");

  a_pop_fills_output: assert property (@(posedge clk) disable iff (rst)
    pop |=> out_valid)
    else $error("popped record did not reach the output register");

  a_reset_clears: assert property (@(posedge clk)
    rst |=> (mask == '0) && !out_valid)
    else $error("reset left records pending");
`endif

endmodule

@@ rtl/byte_or_bit_rle_encoder_top.sv @@
// channel   dir  beat contents
// s_axis    in   tdata[7:0] data_byte, tdata[11:8] bit_count, tlast end_of_vector
// m_axis    out  tdata[7:0] run_value, tdata[22:8] run_length, tlast last_record
// cfg       in   cfg_wr_en / cfg_wr_data = packed_bit_mode
//
// one input beat per cycle while the buffer drains; records leave one per cycle
// an item of more than one record holds s_axis_tready low until its last pops
// eight symbol lanes and one merge step settle run state in the accepting cycle
// rst is synchronous and clears the mode, open run, buffer and output register
// m_axis_tready low holds the output register and then the buffer, then s_axis
module byte_or_bit_rle_encoder_top
  import borle_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // data_byte, bit_count
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // run_value, run_length
  output logic        m_axis_tlast,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data
);

  logic             packed_bit_mode;
  logic [SYM_W-1:0] cur_sym;
  logic [CNT_W-1:0] run_count;

  logic [SYM_W-1:0]  data_byte;
  logic [NSYM_W-1:0] bit_count;
  logic [NSYM_W-1:0] nsym;
  logic              accept;
  lane_t             lanes [LANES];
  logic [LANES-1:0]  brk;
  rec_t              recs [RECS];
  logic [RECS-1:0]   rec_mask;
  logic [SYM_W-1:0]  sym_end;
  logic [CNT_W-1:0]  count_end;
  logic              seen_chg;
  logic              have_brk;
  logic [NSYM_W-1:0] last_j;
  logic              lim;
  rec_t              out_rec;

  assign data_byte = s_axis_tdata[7:0];
  assign bit_count = s_axis_tdata[11:8];
  assign accept    = s_axis_tvalid && s_axis_tready;

  // symbols carried by this beat
  always_comb begin
    if (packed_bit_mode) begin
      nsym = (bit_count > BITS_MAX) ? BITS_MAX : bit_count;
    end else begin
      nsym = {{(NSYM_W-1){1'b0}}, 1'b1};
    end
  end

  // symbol lanes
  for (genvar b = 0; b < LANES; b++) begin : g_lane
    borle_lane u_lane (
      .mode_byte (!packed_bit_mode),
      .active    (NSYM_W'(b) < nsym),
      .data_bit  (data_byte[b]),
      .data_byte (data_byte),
      .prev_open ((b == 0) ? (run_count != '0) : 1'b1),
      .prev_sym  ((b == 0) ? cur_sym : lanes[(b == 0) ? 0 : b-1].sym),
      .run_count (run_count),
      .lane_idx  (LANE_W'(b)),
      .lane      (lanes[b])
    );
  end

  // merge lanes into break records and the run state left behind
  always_comb begin
    seen_chg = 1'b0;
    have_brk = 1'b0;
    last_j   = '0;
    sym_end  = cur_sym;
    brk      = '0;
    for (int b = 0; b < LANES; b++) begin
      lim    = lanes[b].active && lanes[b].lim_hit && !seen_chg;
      brk[b] = lanes[b].chg || lim;
      recs[b].value  = (b == 0) ? cur_sym : lanes[(b == 0) ? 0 : b-1].sym;
      recs[b].length = have_brk ? {{(CNT_W-NSYM_W){1'b0}}, NSYM_W'(b) - last_j}
                                : lanes[b].cnt_at;
      recs[b].last   = 1'b0;
      seen_chg = seen_chg || lanes[b].chg;
      if (brk[b]) begin
        have_brk = 1'b1;
        last_j   = NSYM_W'(b);
      end
      if (lanes[b].active) begin
        sym_end = lanes[b].sym;
      end
    end
    count_end = have_brk ? {{(CNT_W-NSYM_W){1'b0}}, nsym - last_j}
                         : run_count + {{(CNT_W-NSYM_W){1'b0}}, nsym};
    // flush record closes the vector
    recs[LANES].value  = sym_end;
    recs[LANES].length = count_end;
    recs[LANES].last   = 1'b1;
    rec_mask = {s_axis_tlast, brk};
  end

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      packed_bit_mode <= 1'b0;
    end else if (cfg_wr_en) begin
      packed_bit_mode <= cfg_wr_data;
    end
  end

  // open run state
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_sym   <= '0;
      run_count <= '0;
    end else if (accept) begin
      if (s_axis_tlast) begin
        cur_sym   <= '0;
        run_count <= '0;
      end else begin
        cur_sym   <= sym_end;
        run_count <= count_end;
      end
    end
  end

  // record buffer and output register
  borle_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .load      (accept),
    .load_mask (rec_mask),
    .load_recs (recs),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_rec   (out_rec)
  );

  assign m_axis_tdata = {1'b0, out_rec.length, out_rec.value};
  assign m_axis_tlast = out_rec.last;

endmodule

@@ tb/byte_or_bit_rle_encoder_top_tb.sv @@
`timescale 1ns / 1ps

module byte_or_bit_rle_encoder_top_tb
  import borle_pkg::*;
();

  localparam int CYCLE_LIMIT  = 8000000;
  localparam int RANDOM_ITEMS = 400;
  localparam int SETTLE       = 4;

  // run predictor and store of records still owed by the block
  class rle_record_model;
    bit               packed_mode;
    logic [SYM_W-1:0] open_sym;
    logic [CNT_W-1:0] open_len;
    rec_t             owed_records[$];
    int               errors;

    function new();
      packed_mode = 1'b0;
      open_sym    = '0;
      open_len    = '0;
      errors      = 0;
    endfunction

    function void close_run(input logic is_last);
      rec_t r;
      r.value  = open_sym;
      r.length = open_len;
      r.last   = is_last;
      owed_records.push_back(r);
    endfunction

    // extend the open run, or close it on a new symbol or a full run
    function void push_symbol(input logic [SYM_W-1:0] sym);
      if ((open_len != '0 && sym != open_sym) || open_len >= RUN_LIMIT) begin
        close_run(1'b0);
        open_len = CNT_W'(1);
      end else begin
        open_len = open_len + 1'b1;
      end
      open_sym = sym;
    endfunction

    // one accepted input beat
    function void take_input(input logic [7:0] data, input logic [3:0] nbits,
                             input logic eov);
      logic [NSYM_W-1:0] n;
      int b;
      if (packed_mode) begin
        n = (nbits > BITS_MAX) ? BITS_MAX : nbits;
        for (b = 0; b < n; b++) push_symbol(SYM_BIT_BASE + data[b]);
      end else begin
        push_symbol(data);
      end
      if (eov) begin
        close_run(1'b1);
        open_sym = '0;
        open_len = '0;
      end
    endfunction

    function void check_record(input logic [SYM_W-1:0] value,
                               input logic [CNT_W-1:0] length, input logic last);
      rec_t want;
      if (owed_records.size() == 0) begin
        $error("unexpected record: run_value %0d run_length %0d last_record %0d",
               value, length, last);
        errors++;
        return;
      end
      want = owed_records.pop_front();
      if (value !== want.value) begin
        $error("run_value: expected %0d, got %0d", want.value, value);
        errors++;
      end
      if (length !== want.length) begin
        $error("run_length: expected %0d, got %0d", want.length, length);
        errors++;
      end
      if (last !== want.last) begin
        $error("last_record: expected %0d, got %0d", want.last, last);
        errors++;
      end
    endfunction

    function int pending();
      return owed_records.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;   // data_byte, bit_count
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;        // run_value, run_length
  logic        m_axis_tlast;
  logic        cfg_wr_en = 1'b0;
  logic        cfg_wr_data = 1'b0;

  rle_record_model board = new();
  int  cycle_count = 0;
  int  out_hold = 0;
  bit  no_gaps = 1'b0;

  byte_or_bit_rle_encoder_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // record sink: random stalls between beats
  always @(negedge clk) begin
    if (out_hold > 0) begin
      m_axis_tready <= 1'b0;
      out_hold = out_hold - 1;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      board.check_record(m_axis_tdata[7:0], m_axis_tdata[22:8], m_axis_tlast);
      out_hold = no_gaps ? 0 : $urandom_range(0, 3);
    end
  end

  // one input beat; entered and left at a falling edge
  task automatic send_item(input logic [7:0] data, input logic [3:0] nbits,
                           input logic eov);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 3);
    repeat (gap) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0000, nbits, data};
    s_axis_tlast  <= eov;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    board.take_input(data, nbits, eov);
    @(negedge clk);
  endtask

  // hold the sender until every owed record is out
  task automatic drain_records();
    s_axis_tvalid <= 1'b0;
    @(negedge clk);
    while (board.pending() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_mode(input logic mode);
    drain_records();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= mode;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    board.packed_mode = mode;
  endtask

  initial begin
    logic [7:0] prev;
    logic [7:0] d;
    logic [3:0] n;
    int vlen;
    int sent;
    int i;

    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // byte symbols at reset value of the mode register
    send_item(8'h00, 4'd0, 1'b0);
    send_item(8'h00, 4'd15, 1'b0);
    send_item(8'hFF, 4'd0, 1'b0);
    send_item(8'hFF, 4'd8, 1'b1);
    send_item(8'h30, 4'd3, 1'b1);

    // packed bits, bit counts zero, in range and above eight
    write_mode(1'b1);
    send_item(8'hA5, 4'd8, 1'b0);
    send_item(8'hFF, 4'd15, 1'b0);
    send_item(8'h00, 4'd0, 1'b0);
    send_item(8'h0F, 4'd4, 1'b1);
    // flush with no open run
    send_item(8'h5A, 4'd0, 1'b1);
    send_item(8'h00, 4'd9, 1'b0);
    // eight changes plus the flush in one beat
    send_item(8'h00, 4'd1, 1'b0);
    send_item(8'h55, 4'd8, 1'b1);

    // mode flips inside a vector: byte '1' meets packed ones
    write_mode(1'b0);
    send_item(8'h31, 4'd0, 1'b0);
    write_mode(1'b1);
    send_item(8'hFF, 4'd3, 1'b0);
    write_mode(1'b0);
    send_item(8'h31, 4'd12, 1'b0);
    send_item(8'h30, 4'd1, 1'b1);

    // full-length runs, no idling
    no_gaps = 1'b1;
    write_mode(1'b1);
    for (i = 0; i < 4096; i++) send_item(8'hFF, 4'd8, 1'b0);
    send_item(8'h00, 4'd8, 1'b1);
    write_mode(1'b0);
    for (i = 0; i < 32767; i++) send_item(8'h7E, 4'd1, 1'b0);
    send_item(8'h7E, 4'd1, 1'b1);

    // random vectors with runs, mode changes and pauses
    sent = 0;
    prev = 8'h00;
    while (sent < RANDOM_ITEMS) begin
      no_gaps = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 3) == 0) write_mode(1'($urandom_range(0, 1)));
      vlen = $urandom_range(1, 10);
      for (i = 0; i < vlen; i++) begin
        case ($urandom_range(0, 5))
          0, 1, 2: d = prev;
          3:       d = $urandom_range(0, 1) ? 8'hFF : 8'h00;
          default: d = 8'($urandom_range(0, 255));
        endcase
        n = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15))
                                        : 4'($urandom_range(1, 8));
        if ($urandom_range(0, 29) == 0) write_mode(1'($urandom_range(0, 1)));
        else if ($urandom_range(0, 39) == 0) drain_records();
        send_item(d, n, i == vlen - 1);
        prev = d;
        sent++;
      end
    end

    // wait out the remaining records
    drain_records();
    repeat (16) @(negedge clk);
    if (board.errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
